// ----- rtl/ppc_pkg.sv -----
`default_nettype none
package ppc_pkg;

  localparam int NUM_VREGS = 4;
  localparam int VIDX_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd4;
  localparam logic [CNT_W-1:0]     VERTEX_COUNT_RST = 3'd4;
  localparam logic [CNT_W-1:0]     MIN_VERTICES     = 3'd3;

  // per-transaction control travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic in_poly;
    logic once;   // one straddling edge seen
    logic done;   // second straddling edge seen, later edges ignored
  } tok_t;

endpackage
`default_nettype wire

// ----- rtl/point_in_polygon_crossings_core.sv -----
`default_nettype none
// Ray crossings point-in-polygon test for a polygon of 3 to MAX_VERTICES vertices.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the clock
//   edge: indexes 0..3 are the vertices (x in the upper COORD_WIDTH bits, y in the
//   lower), index 4 the vertex count (saturated to 3..MAX_VERTICES). Write only
//   while no transaction is in flight.
// Query: a transaction is accepted at an edge where start is high and busy is low.
//   busy stays low, so a new point can be accepted every cycle.
// Result: valid_o pulses for one cycle with inside_res_o, in acceptance order.
// Structure: one cell per polygon edge, each with two register stages (cross
//   products, then compare). The cell chain depth sets the latency; one point
//   enters per cycle.
// Reset: vertices clear to 0, count to 4, the chain empties.
// The receiver cannot stall; results are presented once and not held.
module point_in_polygon_crossings_core #(
  parameter int MAX_VERTICES = 4,
  parameter int COORD_WIDTH  = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  wire                                   cfg_we_i,
  input  wire [ppc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [2*COORD_WIDTH-1:0]               cfg_wdata_i,
  output logic                                  valid_o,
  output logic                                  inside_res_o
);

  localparam int VW  = 2 * COORD_WIDTH;
  localparam int LAT = 2 * MAX_VERTICES;

  logic [VW-1:0]                  vtx_q [ppc_pkg::NUM_VREGS];
  logic [ppc_pkg::CNT_W-1:0]      count_q;
  logic [ppc_pkg::CNT_W-1:0]      n_eff;
  logic [ppc_pkg::VIDX_W-1:0]     last_idx;
  logic                           accept;

  ppc_pkg::tok_t                  tok [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0]  px [MAX_VERTICES+1];
  logic signed [COORD_WIDTH-1:0]  py [MAX_VERTICES+1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppc_pkg::NUM_VREGS; i++) begin
        vtx_q[i] <= '0;
      end
      count_q <= ppc_pkg::VERTEX_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < ppc_pkg::CFG_IDX_W'(ppc_pkg::NUM_VREGS)) begin
        vtx_q[cfg_idx_i[ppc_pkg::VIDX_W-1:0]] <= cfg_wdata_i;
      end else if (cfg_idx_i == ppc_pkg::REG_VERTEX_COUNT) begin
        count_q <= cfg_wdata_i[ppc_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (count_q < ppc_pkg::MIN_VERTICES) begin
      n_eff = ppc_pkg::MIN_VERTICES;
    end else if (count_q > ppc_pkg::CNT_W'(MAX_VERTICES)) begin
      n_eff = ppc_pkg::CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = count_q;
    end
  end

  assign last_idx = ppc_pkg::VIDX_W'(n_eff - 3'd1);

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept;
    px[0]         = point_x_i;
    py[0]         = point_y_i;
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic [VW-1:0] prev_v;
    logic [VW-1:0] cur_v;

    if (k == 0) begin : g_close
      assign prev_v = vtx_q[last_idx];
    end else begin : g_open
      assign prev_v = vtx_q[k-1];
    end
    assign cur_v = vtx_q[k];

    ppc_cell #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (ppc_pkg::CNT_W'(k) < n_eff),
      .prev_x_i ($signed(prev_v[VW-1:COORD_WIDTH])),
      .prev_y_i ($signed(prev_v[COORD_WIDTH-1:0])),
      .cur_x_i  ($signed(cur_v[VW-1:COORD_WIDTH])),
      .cur_y_i  ($signed(cur_v[COORD_WIDTH-1:0])),
      .tok_i    (tok[k]),
      .px_i     (px[k]),
      .py_i     (py[k]),
      .tok_o    (tok[k+1]),
      .px_o     (px[k+1]),
      .py_o     (py[k+1])
    );
  end

  assign valid_o      = tok[MAX_VERTICES].valid;
  assign inside_res_o = tok[MAX_VERTICES].in_poly;

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result strobe without accepted transaction");

  a_in_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("accepted transaction produced no result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_eff >= ppc_pkg::MIN_VERTICES && n_eff <= ppc_pkg::CNT_W'(MAX_VERTICES))
    else $error("effective vertex count out of range");

endmodule
`default_nettype wire

// ----- rtl/ppc_cell.sv -----
`default_nettype none
module ppc_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           active_i,
  input  wire logic signed [COORD_WIDTH-1:0] prev_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] prev_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] cur_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] cur_y_i,
  input  wire ppc_pkg::tok_t            tok_i,
  input  wire logic signed [COORD_WIDTH-1:0] px_i,
  input  wire logic signed [COORD_WIDTH-1:0] py_i,
  output ppc_pkg::tok_t                 tok_o,
  output logic signed [COORD_WIDTH-1:0] px_o,
  output logic signed [COORD_WIDTH-1:0] py_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] dxa, dy, dyb, dxb;
  logic signed [PW-1:0] p1_d, p2_d;
  logic                 yf0, yf1, xf0, xf1, hit_d;

  ppc_pkg::tok_t        a_tok_q;
  logic signed [COORD_WIDTH-1:0] a_px_q, a_py_q;
  logic signed [PW-1:0] a_p1_q, a_p2_q;
  logic                 a_hit_q, a_simple_q, a_xf0_q, a_dypos_q;

  ppc_pkg::tok_t        b_tok_d, b_tok_q;
  logic signed [COORD_WIDTH-1:0] b_px_q, b_py_q;
  logic                 tog;

  // stage A: straddle test and the two cross products
  assign yf0 = prev_y_i >= py_i;
  assign yf1 = cur_y_i >= py_i;
  assign xf0 = prev_x_i >= px_i;
  assign xf1 = cur_x_i >= px_i;
  assign hit_d = tok_i.valid & active_i & ~tok_i.done & (yf0 ^ yf1);

  assign dxa = DW'(cur_x_i) - DW'(px_i);
  assign dy  = DW'(prev_y_i) - DW'(cur_y_i);
  assign dyb = DW'(cur_y_i) - DW'(py_i);
  assign dxb = DW'(prev_x_i) - DW'(cur_x_i);
  assign p1_d = PW'(dxa) * PW'(dy);
  assign p2_d = PW'(dyb) * PW'(dxb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tok_q <= '0;
    end else begin
      a_tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q     <= px_i;
    a_py_q     <= py_i;
    a_p1_q     <= p1_d;
    a_p2_q     <= p2_d;
    a_hit_q    <= hit_d;
    a_simple_q <= xf0 == xf1;
    a_xf0_q    <= xf0;
    a_dypos_q  <= dy > 0;
  end

  // stage B: intercept compare and toggle
  always_comb begin
    tog = a_hit_q & (a_simple_q ? a_xf0_q :
                     (a_dypos_q ? (a_p1_q >= a_p2_q) : (a_p1_q <= a_p2_q)));
    b_tok_d = a_tok_q;
    b_tok_d.in_poly = a_tok_q.in_poly ^ tog;
    if (a_hit_q) begin
      b_tok_d.done = a_tok_q.once;
      b_tok_d.once = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tok_q <= '0;
    end else begin
      b_tok_q <= b_tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_px_q <= a_px_q;
    b_py_q <= a_py_q;
  end

  assign tok_o = b_tok_q;
  assign px_o  = b_px_q;
  assign py_o  = b_py_q;

endmodule
`default_nettype wire
